// ===== rtl/session_stat_counters_defines.svh =====
// Assertion macros used by the session statistics RTL.
`ifndef SESSION_STAT_COUNTERS_DEFINES_SVH
`define SESSION_STAT_COUNTERS_DEFINES_SVH

`ifndef SYNTHESIS
`define SSC_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("session stat counters: assertion failed");
`define SSC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("session stat counters: assertion failed");
`else
`define SSC_ASSERT_IMPL(name, ante, cons)
`define SSC_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== rtl/ssc_pkg.sv =====
// Types and constants for the session statistics counters.
`timescale 1ns / 1ps

package ssc_pkg;

  localparam int MaxSessions = 1024;
  localparam int NumTotals   = 10;
  localparam int ModeW       = 4;
  localparam int AmountW     = 64;
  localparam int ActiveW     = 11;
  localparam int GaugeW      = $clog2(MaxSessions + 1);
  localparam int AddrW       = $clog2(NumTotals);

  typedef enum logic [ModeW-1:0] {
    MODE_CREATED   = 4'd0,
    MODE_CLOSED    = 4'd1,
    MODE_BYTES_C2B = 4'd2,
    MODE_BYTES_B2C = 4'd3,
    MODE_DGRAM_C2B = 4'd4,
    MODE_DGRAM_B2C = 4'd5,
    MODE_REJECTED  = 4'd6,
    MODE_DROPPED   = 4'd7,
    MODE_ERROR     = 4'd8,
    MODE_TIMEOUT   = 4'd9
  } ssc_mode_e;

  typedef struct packed {
    logic               en;
    logic [AddrW-1:0]   addr;
    logic [AmountW-1:0] data;
  } ssc_wr_t;

endpackage

// ===== rtl/ssc_total_ram.sv =====
// Total store: synchronous memory with per-entry valid bits and write forwarding.
`timescale 1ns / 1ps

module ssc_total_ram (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rd_en_i,
  input  logic [ssc_pkg::ModeW-1:0]      rd_addr_i,
  output logic [ssc_pkg::AmountW-1:0]    rd_data_o,
  input  ssc_pkg::ssc_wr_t               wr_i
);

  logic [ssc_pkg::AmountW-1:0]   mem [ssc_pkg::NumTotals];
  logic [ssc_pkg::NumTotals-1:0] vld_q;
  logic [ssc_pkg::AmountW-1:0]   rd_data_q;
  logic [ssc_pkg::AddrW-1:0]     rd_idx;
  logic                          rd_in_range;
  logic                          rd_hit_wr;

  assign rd_idx      = rd_addr_i[ssc_pkg::AddrW-1:0];
  assign rd_in_range = (rd_addr_i < ssc_pkg::ModeW'(ssc_pkg::NumTotals));
  assign rd_hit_wr   = wr_i.en && (wr_i.addr == rd_idx);

  // Entries read as zero until first written after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      // Forward a same-cycle write to the same entry.
      if (!rd_in_range) begin
        rd_data_q <= '0;
      end else if (rd_hit_wr) begin
        rd_data_q <= wr_i.data;
      end else if (vld_q[rd_idx]) begin
        rd_data_q <= mem[rd_idx];
      end else begin
        rd_data_q <= '0;
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/session_stat_counters.sv =====
// Session statistics counters: ten saturating 64-bit totals and a session gauge.
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+------------------------------------------
//  event    | start, busy               | mode_i, amount_i
//  result   | valid_o (one-cycle strobe)| accepted_o, total_value_o,
//           |                           | active_sessions_o, saturated_o
//  config   | cfg_valid_i, cfg_ready_o  | cfg_data_i (protocol_udp)
//
// One event per cycle; busy stays low. The total is read from the memory in the
// accept cycle, updated and written back in the next; the result registers load
// at the end of the write-back cycle. A write to the entry being read is
// forwarded at the memory read port. Reset clears all totals at once through
// per-entry valid bits; there is no clearing pass. The receiver cannot stall.
`timescale 1ns / 1ps
`include "session_stat_counters_defines.svh"

module session_stat_counters (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [ssc_pkg::ModeW-1:0]        mode_i,
  input  logic [ssc_pkg::AmountW-1:0]      amount_i,
  output logic                             valid_o,
  output logic                             accepted_o,
  output logic [ssc_pkg::AmountW-1:0]      total_value_o,
  output logic [ssc_pkg::ActiveW-1:0]      active_sessions_o,
  output logic                             saturated_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_data_i
);

  localparam logic [ssc_pkg::GaugeW-1:0] MaxGauge = ssc_pkg::GaugeW'(ssc_pkg::MaxSessions);

  logic                          accept;
  logic                          udp_q;
  logic                          s1_valid_q;
  logic [ssc_pkg::ModeW-1:0]     s1_mode_q;
  logic [ssc_pkg::AmountW-1:0]   s1_amount_q;
  logic [ssc_pkg::AmountW-1:0]   cur_total;
  logic [ssc_pkg::AmountW-1:0]   new_total;
  logic                          hits_top;
  logic                          ok;
  logic                          amount_is_one;
  ssc_pkg::ssc_wr_t              wr;
  logic [ssc_pkg::GaugeW-1:0]    gauge_q, gauge_d;
  logic                          sat_q, sat_d;
  logic                          valid_q;
  logic                          accepted_q;
  logic [ssc_pkg::AmountW-1:0]   total_q;

  assign busy        = 1'b0;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      udp_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      udp_q <= cfg_data_i;
    end
  end

  ssc_total_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (mode_i),
    .rd_data_o (cur_total),
    .wr_i      (wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q   <= mode_i;
      s1_amount_q <= amount_i;
    end
  end

  assign amount_is_one = (s1_amount_q == ssc_pkg::AmountW'(1));

  always_comb begin
    unique case (ssc_pkg::ssc_mode_e'(s1_mode_q)) inside
      ssc_pkg::MODE_CREATED:
        ok = amount_is_one && (gauge_q < MaxGauge);
      ssc_pkg::MODE_CLOSED:
        ok = amount_is_one && (gauge_q != '0);
      ssc_pkg::MODE_DGRAM_C2B, ssc_pkg::MODE_DGRAM_B2C, ssc_pkg::MODE_DROPPED:
        ok = udp_q;
      ssc_pkg::MODE_BYTES_C2B, ssc_pkg::MODE_BYTES_B2C, ssc_pkg::MODE_REJECTED,
      ssc_pkg::MODE_ERROR, ssc_pkg::MODE_TIMEOUT:
        ok = 1'b1;
      default:
        ok = 1'b0;
    endcase
  end

  // Saturate when amount >= all-ones minus current total.
  assign hits_top  = (s1_amount_q >= ~cur_total);
  assign new_total = hits_top ? '1 : (cur_total + s1_amount_q);

  assign wr.en   = s1_valid_q && ok;
  assign wr.addr = s1_mode_q[ssc_pkg::AddrW-1:0];
  assign wr.data = new_total;

  always_comb begin
    gauge_d = gauge_q;
    sat_d   = sat_q;
    if (wr.en) begin
      if (s1_mode_q == ssc_pkg::MODE_CREATED) begin
        gauge_d = gauge_q + ssc_pkg::GaugeW'(1);
      end else if (s1_mode_q == ssc_pkg::MODE_CLOSED) begin
        gauge_d = gauge_q - ssc_pkg::GaugeW'(1);
      end
      if (hits_top) begin
        sat_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gauge_q <= '0;
      sat_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      gauge_q <= gauge_d;
      sat_q   <= sat_d;
      valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      accepted_q <= ok;
      total_q    <= ok ? new_total : '0;
    end
  end

  assign valid_o           = valid_q;
  assign accepted_o        = accepted_q;
  assign total_value_o     = total_q;
  assign active_sessions_o = gauge_q[ssc_pkg::ActiveW-1:0];
  assign saturated_o       = sat_q;

  `SSC_ASSERT_IMPL(a_gauge_bounded, 1'b1, gauge_q <= MaxGauge)
  `SSC_ASSERT_NEXT(a_sat_sticky, sat_q, sat_q)
  `SSC_ASSERT_IMPL(a_refused_zero, valid_o && !accepted_o, total_value_o == '0)
  `SSC_ASSERT_NEXT(a_strobe_follows, !s1_valid_q, !valid_q)
  `SSC_ASSERT_IMPL(a_sat_shows_top, wr.en && hits_top, new_total == '1)

endmodule

// ===== tb/tb_session_stat_counters.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the session statistics counters.
module tb_session_stat_counters;
  import ssc_pkg::*;

  typedef struct {
    logic               accepted;
    logic [AmountW-1:0] total;
    logic [ActiveW-1:0] active;
    logic               saturated;
  } stat_result_t;

  class stat_scoreboard;
    logic [AmountW-1:0] totals [NumTotals];
    int unsigned        gauge;
    bit                 sat_flag;
    bit                 udp_mode;
    stat_result_t       pending_results[$];
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        counted;

    function new();
      foreach (totals[k]) totals[k] = '0;
      gauge    = 0;
      sat_flag = 1'b0;
      udp_mode = 1'b0;
      errors   = 0;
      checked  = 0;
      counted  = 0;
    endfunction

    function void set_protocol(bit udp);
      udp_mode = udp;
    endfunction

    // Apply one accepted event to the shadow counters and queue its result.
    function void note_event(logic [ModeW-1:0] mode, logic [AmountW-1:0] amount);
      stat_result_t r;
      bit           ok;
      ok = 1'b1;
      case (mode)
        MODE_CREATED: ok = (amount == 1) && (gauge < MaxSessions);
        MODE_CLOSED:  ok = (amount == 1) && (gauge != 0);
        MODE_DGRAM_C2B, MODE_DGRAM_B2C, MODE_DROPPED: ok = udp_mode;
        MODE_BYTES_C2B, MODE_BYTES_B2C, MODE_REJECTED, MODE_ERROR, MODE_TIMEOUT: ok = 1'b1;
        default: ok = 1'b0;
      endcase
      r.accepted = ok;
      r.total    = '0;
      if (ok) begin
        if (mode == MODE_CREATED) gauge++;
        else if (mode == MODE_CLOSED) gauge--;
        // Saturate once the amount reaches the headroom left in the total.
        if (amount >= ~totals[mode]) begin
          totals[mode] = '1;
          sat_flag     = 1'b1;
        end else begin
          totals[mode] = totals[mode] + amount;
        end
        r.total = totals[mode];
      end
      r.active    = ActiveW'(gauge);
      r.saturated = sat_flag;
      pending_results.push_back(r);
    endfunction

    function void check_result(stat_result_t got);
      stat_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: accepted=%0b total=%h active=%0d sat=%0b",
                 $time, got.accepted, got.total, got.active, got.saturated);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (want.accepted) counted++;
      if (got.accepted !== want.accepted) begin
        $display("%0t: accepted mismatch: expected %0b, actual %0b",
                 $time, want.accepted, got.accepted);
        errors++;
      end
      if (got.total !== want.total) begin
        $display("%0t: total_value mismatch: expected %h, actual %h",
                 $time, want.total, got.total);
        errors++;
      end
      if (got.active !== want.active) begin
        $display("%0t: active_sessions mismatch: expected %0d, actual %0d",
                 $time, want.active, got.active);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated mismatch: expected %0b, actual %0b",
                 $time, want.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [ModeW-1:0]   mode_i;
  logic [AmountW-1:0] amount_i;
  logic               valid_o;
  logic               accepted_o;
  logic [AmountW-1:0] total_value_o;
  logic [ActiveW-1:0] active_sessions_o;
  logic               saturated_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_data_i;

  stat_scoreboard sb;
  stat_result_t   seen;
  int unsigned    events_sent;

  session_stat_counters dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .mode_i            (mode_i),
    .amount_i          (amount_i),
    .valid_o           (valid_o),
    .accepted_o        (accepted_o),
    .total_value_o     (total_value_o),
    .active_sessions_o (active_sessions_o),
    .saturated_o       (saturated_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1) begin
      seen.accepted  = accepted_o;
      seen.total     = total_value_o;
      seen.active    = active_sessions_o;
      seen.saturated = saturated_o;
      sb.check_result(seen);
    end
  end

  // Hold start high until the transaction is taken.
  task automatic send_event(input logic [ModeW-1:0] m, input logic [AmountW-1:0] a);
    start    <= 1'b1;
    mode_i   <= m;
    amount_i <= a;
    do @(posedge clk_i); while (busy);
    sb.note_event(m, a);
    events_sent++;
  endtask

  task automatic idle_cycles(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_protocol(input bit udp);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= udp;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_protocol(udp);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mix small adds, wide values and amounts right at the headroom of the total.
  function automatic logic [AmountW-1:0] pick_amount(logic [ModeW-1:0] m);
    logic [AmountW-1:0] room;
    int unsigned        sel;
    sel  = $urandom_range(0, 99);
    room = (m < NumTotals) ? ~sb.totals[m] : {$urandom(), $urandom()};
    if ((m == MODE_CREATED || m == MODE_CLOSED) && sel < 85) return 1;
    if (sel < 50) return $urandom_range(0, 1000);
    if (sel < 60) return {$urandom(), $urandom()};
    if (sel < 70) return room + AmountW'($urandom_range(0, 2)) - 1;
    if (sel < 85) return room >> $urandom_range(1, 12);
    if (sel < 92) return '1;
    return '0;
  endfunction

  task automatic run_mix(input int unsigned count, input bit idling);
    logic [ModeW-1:0] m;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) m = ModeW'($urandom_range(0, 15));
      else m = ModeW'($urandom_range(0, NumTotals - 1));
      send_event(m, pick_amount(m));
      if (idling && $urandom_range(0, 99) < 12) idle_cycles(1);
    end
  endtask

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int unsigned wait_n;
    bit          udp;
    sb          = new();
    events_sent = 0;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    mode_i      <= '0;
    amount_i    <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_protocol(1'b0);
    send_event(MODE_CREATED, 1);
    send_event(MODE_CREATED, 0);
    send_event(MODE_CREATED, 2);
    send_event(MODE_CLOSED, 1);
    send_event(MODE_CLOSED, 1);
    send_event(MODE_CLOSED, '1);
    send_event(MODE_DGRAM_C2B, 5);
    send_event(MODE_DGRAM_B2C, 5);
    send_event(MODE_DROPPED, 1);
    send_event(MODE_REJECTED, 5);
    send_event(MODE_ERROR, 7);
    send_event(MODE_TIMEOUT, 64'hFFFF);
    send_event(ModeW'(10), 1);
    send_event(ModeW'(15), '1);
    drain_results();

    write_protocol(1'b1);
    send_event(MODE_DGRAM_C2B, 3);
    send_event(MODE_DGRAM_B2C, 64'h8000_0000_0000_0000);
    send_event(MODE_DROPPED, 1);
    send_event(ModeW'(12), 4);
    // Approach the top of a total one step short, then land on it exactly.
    send_event(MODE_BYTES_B2C, '1 - 64'd1);
    send_event(MODE_BYTES_B2C, 0);
    send_event(MODE_BYTES_B2C, 1);
    send_event(MODE_BYTES_C2B, '1);
    send_event(MODE_BYTES_C2B, 0);
    drain_results();

    for (int b = 0; b < 8; b++) begin
      drain_results();
      udp = (b == 0) ? 1'b0 : (b == 1) ? 1'b1 : 1'($urandom_range(0, 1));
      write_protocol(udp);
      run_mix(95, b != 4);
    end

    start <= 1'b0;
    for (wait_n = 0; wait_n < 1000 && sb.pending_results.size() != 0; wait_n++)
      @(posedge clk_i);
    if (sb.pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending_results.size());
      sb.errors += sb.pending_results.size();
    end
    repeat (4) @(posedge clk_i);

    $display("Sent %0d events (%0d counted, %0d refused) over TCP and UDP settings,",
             events_sent, sb.counted, sb.checked - sb.counted);
    $display("including refused kinds, a close on an empty gauge and saturation at the top.");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
